### src/dsmrc_pkg.sv
`default_nettype none

package dsmrc_pkg;

  // Parameter defaults
  localparam int FRAME_BYTES_DEF  = 16;
  localparam int WORDS_DEF        = 7;
  localparam int MAX_CHANNELS_DEF = 16;

  // Frame byte store
  localparam int STORE_DEPTH = 16;
  localparam int STORE_AW    = 4;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int SLOT_W  = 4;
  localparam int PULSE_W = 12;
  localparam int COUNT_W = 5;
  localparam int WORD_W  = 3;
  localparam int VAL_W   = 11;
  localparam int PROD_W  = 22;

  // Register indexes on the configuration port
  typedef enum logic {
    CFG_WIDE_VALUES = 1'b0,
    CFG_GAP_LIMIT   = 1'b1
  } cfg_idx_t;

  // Input operation codes
  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  // Reset values and scaling constants
  localparam logic                WIDE_RESET   = 1'b1;
  localparam logic [BYTE_W-1:0]   GAP_RESET    = 8'd5;
  localparam logic [BYTE_W-1:0]   IDLE_MAX     = 8'hff;
  localparam logic [VAL_W-1:0]    PULSE_SCALE  = 11'd1200;
  localparam logic [PULSE_W-1:0]  PULSE_BASE   = 12'd900;
  localparam logic [COUNT_W-1:0]  COUNT_CLAMP  = 5'd13;
  localparam logic [COUNT_W-1:0]  COUNT_LIMIT  = 5'd12;

  // Decode sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_HI,
    S_RD_LO,
    S_MUL,
    S_EMIT
  } state_t;

  // Channels 0,1,2 land in slots 2,0,1
  function automatic logic [SLOT_W-1:0] remap_slot(input logic [SLOT_W-1:0] ch);
    logic [SLOT_W-1:0] s;
    unique case (ch)
      4'd0:    s = 4'd2;
      4'd1:    s = 4'd0;
      4'd2:    s = 4'd1;
      default: s = ch;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### src/dsmrc_in_if.sv
`default_nettype none

interface dsmrc_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

`default_nettype wire

### src/dsmrc_out_if.sv
`default_nettype none

interface dsmrc_out_if;
  logic        valid;
  logic        ready;
  logic        word_valid;
  logic [3:0]  slot;
  logic [11:0] pulse_value;
  logic [4:0]  channel_count;
  logic        last;

  modport source (output valid, output word_valid, output slot, output pulse_value,
                  output channel_count, output last, input ready);
  modport sink   (input valid, input word_valid, input slot, input pulse_value,
                  input channel_count, input last, output ready);
endinterface

`default_nettype wire

### src/dsmrc_cfg_if.sv
`default_nettype none

interface dsmrc_cfg_if;
  logic       valid;
  logic       ready;
  logic       reg_index;
  logic [7:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

### src/dsm_rc_frame_decoder_unit.sv
// Tick or non-final byte: accepted while idle; ready stays high afterwards.
// Frame-ending byte: stored, then each word goes RD_HI, RD_LO (two reads on the
// single byte-store read port), MUL (one multiply), EMIT (one output load).
// Results leave through an output register; a stalled sink holds the sequencer.
// Synchronous active-low reset clears state, position, idle count, channel
// count, word index and output valid; payload and byte store are not cleared.
`default_nettype none

module dsm_rc_frame_decoder_unit #(
  parameter int FRAME_BYTES     = dsmrc_pkg::FRAME_BYTES_DEF,
  parameter int WORDS_PER_FRAME = dsmrc_pkg::WORDS_DEF,
  parameter int MAX_CHANNELS    = dsmrc_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  dsmrc_in_if.sink      in_ch,
  dsmrc_out_if.source   out_ch,
  dsmrc_cfg_if.sink     cfg_ch
);

  dsmrc_pkg::state_t state_r, state_nxt;

  // configuration
  logic                           wide_r;
  logic [dsmrc_pkg::BYTE_W-1:0]   gap_r;

  // frame collection
  logic [dsmrc_pkg::STORE_AW-1:0] pos_r, pos_nxt;
  logic [dsmrc_pkg::BYTE_W-1:0]   idle_r, idle_nxt;
  logic [dsmrc_pkg::COUNT_W-1:0]  cnt_r, cnt_nxt;

  // decode datapath
  logic [dsmrc_pkg::WORD_W-1:0]   word_r, word_nxt;
  logic [dsmrc_pkg::BYTE_W-1:0]   hi_r, hi_nxt;
  logic [dsmrc_pkg::SLOT_W-1:0]   ch_r, ch_nxt;
  logic                           vld_r, vld_nxt;
  logic [dsmrc_pkg::PROD_W-1:0]   prod_r, prod_nxt;

  // output register
  logic                           ov_r, ov_nxt;
  logic                           o_wv_r, o_wv_nxt;
  logic [dsmrc_pkg::SLOT_W-1:0]   o_slot_r, o_slot_nxt;
  logic [dsmrc_pkg::PULSE_W-1:0]  o_pulse_r, o_pulse_nxt;
  logic [dsmrc_pkg::COUNT_W-1:0]  o_cnt_r, o_cnt_nxt;
  logic                           o_last_r, o_last_nxt;

  // byte store
  logic                           ram_we;
  logic [dsmrc_pkg::STORE_AW-1:0] ram_waddr, ram_raddr;
  logic [dsmrc_pkg::BYTE_W-1:0]   ram_rdata;

  logic                                 in_acc, is_byte, frame_done, out_free, word_last;
  logic [dsmrc_pkg::STORE_AW-1:0]       pos_start, addr_hi;
  logic [dsmrc_pkg::STORE_AW:0]         pos_inc;
  logic [15:0]                          raw;
  logic [dsmrc_pkg::VAL_W-1:0]          val, scaled;
  logic [dsmrc_pkg::SLOT_W-1:0]         ch_w;
  logic [dsmrc_pkg::COUNT_W-1:0]        cnt_up;

  // shared helpers
  assign in_acc     = in_ch.valid && in_ch.ready;
  assign is_byte    = (dsmrc_pkg::op_t'(in_ch.operation) == dsmrc_pkg::OP_BYTE);
  assign pos_start  = (idle_r > gap_r) ? '0 : pos_r;
  assign pos_inc    = {1'b0, pos_start} + 5'd1;
  assign frame_done = (pos_inc >= 5'(FRAME_BYTES));
  assign out_free   = !ov_r || out_ch.ready;
  assign word_last  = (word_r == 3'(WORDS_PER_FRAME - 1));
  assign addr_hi    = 4'({word_r, 1'b0}) + 4'd2;

  assign ram_waddr  = pos_start;

  dsmrc_ram #(
    .WIDTH (dsmrc_pkg::BYTE_W),
    .DEPTH (dsmrc_pkg::STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (in_ch.rx_byte),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  // configuration writes
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r <= dsmrc_pkg::WIDE_RESET;
      gap_r  <= dsmrc_pkg::GAP_RESET;
    end else if (cfg_ch.valid) begin
      unique case (dsmrc_pkg::cfg_idx_t'(cfg_ch.reg_index))
        dsmrc_pkg::CFG_WIDE_VALUES: wide_r <= cfg_ch.wdata[0];
        dsmrc_pkg::CFG_GAP_LIMIT:   gap_r  <= cfg_ch.wdata;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dsmrc_pkg::S_IDLE:  if (in_acc && is_byte && frame_done) state_nxt = dsmrc_pkg::S_RD_HI;
      dsmrc_pkg::S_RD_HI: state_nxt = dsmrc_pkg::S_RD_LO;
      dsmrc_pkg::S_RD_LO: state_nxt = dsmrc_pkg::S_MUL;
      dsmrc_pkg::S_MUL:   state_nxt = dsmrc_pkg::S_EMIT;
      dsmrc_pkg::S_EMIT: begin
        if (out_free) begin
          state_nxt = word_last ? dsmrc_pkg::S_IDLE : dsmrc_pkg::S_RD_HI;
        end
      end
      default: state_nxt = dsmrc_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ch.ready = 1'b0;
    ram_we      = 1'b0;
    ram_raddr   = addr_hi;
    unique case (state_r)
      dsmrc_pkg::S_IDLE: begin
        // ready is always high here, so valid alone marks the transaction
        in_ch.ready = 1'b1;
        ram_we      = in_ch.valid && is_byte;
      end
      dsmrc_pkg::S_RD_HI: ram_raddr = addr_hi;
      dsmrc_pkg::S_RD_LO: ram_raddr = addr_hi | 4'd1;
      dsmrc_pkg::S_MUL:   ram_raddr = addr_hi;
      dsmrc_pkg::S_EMIT:  ram_raddr = addr_hi;
      default:            ram_raddr = addr_hi;
    endcase
  end

  // word fields from the two stored bytes
  assign raw  = {hi_r, ram_rdata};
  assign ch_w = wide_r ? raw[14:11] : raw[13:10];
  assign val  = wide_r ? raw[10:0] : {1'b0, raw[9:0]};

  // scaled value and running count
  assign scaled = wide_r ? prod_r[21:11] : prod_r[20:10];
  assign cnt_up = (vld_r && ({1'b0, ch_r} >= cnt_r)) ? ({1'b0, ch_r} + 5'd1) : cnt_r;

  // datapath next values
  always_comb begin
    pos_nxt     = pos_r;
    idle_nxt    = idle_r;
    cnt_nxt     = cnt_r;
    word_nxt    = word_r;
    hi_nxt      = hi_r;
    ch_nxt      = ch_r;
    vld_nxt     = vld_r;
    prod_nxt    = prod_r;
    ov_nxt      = ov_r && !out_ch.ready;
    o_wv_nxt    = o_wv_r;
    o_slot_nxt  = o_slot_r;
    o_pulse_nxt = o_pulse_r;
    o_cnt_nxt   = o_cnt_r;
    o_last_nxt  = o_last_r;

    // byte or tick transaction
    if (in_acc) begin
      if (is_byte) begin
        idle_nxt = '0;
        pos_nxt  = frame_done ? '0 : pos_inc[dsmrc_pkg::STORE_AW-1:0];
        word_nxt = '0;
      end else if (idle_r != dsmrc_pkg::IDLE_MAX) begin
        idle_nxt = idle_r + 8'd1;
      end
    end

    if (state_r == dsmrc_pkg::S_RD_LO) begin
      hi_nxt = ram_rdata;
    end

    // one multiply per word
    if (state_r == dsmrc_pkg::S_MUL) begin
      ch_nxt   = ch_w;
      vld_nxt  = ({1'b0, ch_w} < 5'(MAX_CHANNELS));
      prod_nxt = dsmrc_pkg::PROD_W'(val) * dsmrc_pkg::PROD_W'(dsmrc_pkg::PULSE_SCALE);
    end

    // load result register
    if (state_r == dsmrc_pkg::S_EMIT && out_free) begin
      ov_nxt      = 1'b1;
      o_wv_nxt    = vld_r;
      o_slot_nxt  = vld_r ? dsmrc_pkg::remap_slot(ch_r) : '0;
      o_pulse_nxt = vld_r ? ({1'b0, scaled} + dsmrc_pkg::PULSE_BASE) : '0;
      cnt_nxt     = (word_last && cnt_up == dsmrc_pkg::COUNT_CLAMP) ?
                    dsmrc_pkg::COUNT_LIMIT : cnt_up;
      o_cnt_nxt   = cnt_nxt;
      o_last_nxt  = word_last;
      word_nxt    = word_r + 3'd1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dsmrc_pkg::S_IDLE;
      pos_r   <= '0;
      idle_r  <= '0;
      cnt_r   <= '0;
      word_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      idle_r  <= idle_nxt;
      cnt_r   <= cnt_nxt;
      word_r  <= word_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hi_r      <= hi_nxt;
    ch_r      <= ch_nxt;
    vld_r     <= vld_nxt;
    prod_r    <= prod_nxt;
    o_wv_r    <= o_wv_nxt;
    o_slot_r  <= o_slot_nxt;
    o_pulse_r <= o_pulse_nxt;
    o_cnt_r   <= o_cnt_nxt;
    o_last_r  <= o_last_nxt;
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.word_valid    = o_wv_r;
  assign out_ch.slot          = o_slot_r;
  assign out_ch.pulse_value   = o_pulse_r;
  assign out_ch.channel_count = o_cnt_r;
  assign out_ch.last          = o_last_r;

  // checks
  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_byte && frame_done) |=> (state_r == dsmrc_pkg::S_RD_HI && word_r == '0))
    else $error("frame-ending byte did not start decode");

  a_no_thirteen: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && o_last_r) |-> (o_cnt_r != dsmrc_pkg::COUNT_CLAMP))
    else $error("count of 13 reported on last word");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !o_wv_r) |-> (o_slot_r == '0 && o_pulse_r == '0))
    else $error("invalid word carries slot or pulse");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, pos_r} < 5'(FRAME_BYTES))
    else $error("byte position beyond frame");

  a_word_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != dsmrc_pkg::S_IDLE) |-> ({1'b0, word_r} < 4'(WORDS_PER_FRAME)))
    else $error("word index beyond frame");

endmodule

`default_nettype wire

### src/dsmrc_ram.sv
`default_nettype none

module dsmrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import dsmrc_pkg::*;

  localparam int FRAME_LEN     = FRAME_BYTES_DEF;
  localparam int WORDS         = WORDS_DEF;
  localparam int MAX_CH        = MAX_CHANNELS_DEF;
  // Extra wait once every expected word is out; leaves margin
  localparam int SETTLE_CYCLES = 40;
  localparam int LIMIT_CYCLES  = 200000;

  // One decoded channel word
  typedef struct packed {
    logic               word_valid;
    logic [SLOT_W-1:0]  slot;
    logic [PULSE_W-1:0] pulse_value;
    logic [COUNT_W-1:0] channel_count;
    logic               last;
  } rc_word_t;

  logic clk = 1'b0;
  logic rst_n;

  dsmrc_in_if  in_if ();
  dsmrc_out_if out_if ();
  dsmrc_cfg_if cfg_if ();

  dsm_rc_frame_decoder_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decoder mirror state
  logic              dec_wide   = WIDE_RESET;
  logic [BYTE_W-1:0] dec_gap    = GAP_RESET;
  logic [BYTE_W-1:0] rx_store [STORE_DEPTH];
  int unsigned       rx_pos     = 0;
  logic [BYTE_W-1:0] idle_count = '0;
  int unsigned       chan_count = 0;
  rc_word_t          pending_words [$];

  // Stimulus-side copy of the settings, used to build words
  logic              cur_wide = WIDE_RESET;
  logic [BYTE_W-1:0] cur_gap  = GAP_RESET;
  logic [15:0]       plan_words [WORDS];

  int error_count = 0;
  int cycle_count = 0;
  int burst_left  = 0;
  int hold_left   = 0;
  logic [15:0] stall_pat = 16'hffff;
  int pat_age = 0;

  // Expected words for a completed frame
  task automatic decode_frame_words();
    int i;
    logic [15:0] raw;
    logic [3:0] ch;
    logic [10:0] val;
    int unsigned scaled;
    rc_word_t w;
    for (i = 0; i < WORDS; i++) begin
      raw = {rx_store[(2 + 2 * i) % STORE_DEPTH], rx_store[(3 + 2 * i) % STORE_DEPTH]};
      if (dec_wide) begin
        ch  = raw[14:11];
        val = raw[10:0];
      end else begin
        ch  = raw[13:10];
        val = {1'b0, raw[9:0]};
      end
      w = '0;
      if (int'(ch) < MAX_CH) begin
        w.word_valid = 1'b1;
        if (ch >= chan_count) chan_count = ch + 1;
        scaled = (int'(val) * int'(PULSE_SCALE)) / (dec_wide ? 2048 : 1024)
                 + int'(PULSE_BASE);
        w.pulse_value = scaled[PULSE_W-1:0];
        // 0,1,2 rotate to 2,0,1
        w.slot = (ch < 3) ? 4'((ch + 2) % 3) : ch;
      end
      if (i == WORDS - 1 && chan_count == COUNT_CLAMP) chan_count = COUNT_LIMIT;
      w.channel_count = 5'(chan_count);
      w.last = (i == WORDS - 1);
      pending_words.push_back(w);
    end
  endtask

  // Advance the mirror by one accepted transaction
  task automatic track_rx_item(op_t op, logic [BYTE_W-1:0] b);
    if (op == OP_TICK) begin
      if (idle_count != IDLE_MAX) idle_count++;
    end else begin
      if (idle_count > dec_gap) rx_pos = 0;
      idle_count = '0;
      rx_store[rx_pos % STORE_DEPTH] = b;
      rx_pos++;
      if (rx_pos >= FRAME_LEN) begin
        rx_pos = 0;
        decode_frame_words();
      end
    end
  endtask

  // Watch the input and configuration handshakes
  always @(posedge clk) begin
    if (!rst_n) begin
      dec_wide   = WIDE_RESET;
      dec_gap    = GAP_RESET;
      rx_pos     = 0;
      idle_count = '0;
      chan_count = 0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_idx_t'(cfg_if.reg_index))
          CFG_WIDE_VALUES: dec_wide = cfg_if.wdata[0];
          CFG_GAP_LIMIT:   dec_gap  = cfg_if.wdata;
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) track_rx_item(op_t'(in_if.operation), in_if.rx_byte);
    end
  end

  task automatic report_mismatch(string what);
    $display("MISMATCH cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // Compare each word transaction against the oldest expectation
  always @(posedge clk) begin
    rc_word_t exp_w;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word slot=%0d pulse=%0d",
                                  out_if.slot, out_if.pulse_value));
      end else begin
        exp_w = pending_words.pop_front();
        if (out_if.word_valid !== exp_w.word_valid)
          report_mismatch($sformatf("word_valid %0b, want %0b",
                                    out_if.word_valid, exp_w.word_valid));
        if (out_if.slot !== exp_w.slot)
          report_mismatch($sformatf("slot %0d, want %0d", out_if.slot, exp_w.slot));
        if (out_if.pulse_value !== exp_w.pulse_value)
          report_mismatch($sformatf("pulse_value %0d, want %0d",
                                    out_if.pulse_value, exp_w.pulse_value));
        if (out_if.channel_count !== exp_w.channel_count)
          report_mismatch($sformatf("channel_count %0d, want %0d",
                                    out_if.channel_count, exp_w.channel_count));
        if (out_if.last !== exp_w.last)
          report_mismatch($sformatf("last %0b, want %0b", out_if.last, exp_w.last));
      end
    end
  end

  // Receiver: rotating stall pattern, refreshed now and then; long hold on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else begin
      if (pat_age == 0) begin
        stall_pat = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
        pat_age = 32;
      end
      out_if.ready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[15:1]};
      pat_age--;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one transaction; sender runs in bursts with random gaps
  task automatic send_item(op_t op, logic [BYTE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.rx_byte   <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    burst_left--;
  endtask

  // Stop offering and wait until every expected word has come out
  task automatic wait_quiet();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [BYTE_W-1:0] d);
    wait_quiet();
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata     <= d;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    if (idx == CFG_WIDE_VALUES) cur_wide = d[0];
    else cur_gap = d;
  endtask

  function automatic logic [15:0] pack_word(logic [3:0] ch, logic [10:0] val,
                                            logic [1:0] top);
    if (cur_wide) return {top[0], ch, val};
    return {top, ch, val[9:0]};
  endfunction

  function automatic void fill_random_words();
    int i;
    logic [10:0] val;
    for (i = 0; i < WORDS; i++) begin
      case ($urandom_range(0, 5))
        0:       val = '0;
        1:       val = 11'h7ff;
        default: val = 11'($urandom);
      endcase
      plan_words[i] = pack_word(($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 2))
                                                            : 4'($urandom_range(0, 15)),
                                val, 2'($urandom));
    end
  endfunction

  // Two header bytes then plan_words; random ticks up to max_ticks between bytes,
  // and break_ticks ticks just before byte break_at
  task automatic send_frame(int max_ticks, int break_at, int break_ticks);
    int k;
    int t;
    logic [BYTE_W-1:0] b;
    for (k = 0; k < FRAME_LEN; k++) begin
      if (k > 0 && max_ticks > 0 && $urandom_range(0, 3) == 0) begin
        t = $urandom_range(1, max_ticks);
        repeat (t) send_item(OP_TICK, 8'($urandom));
      end
      if (k == break_at) repeat (break_ticks) send_item(OP_TICK, 8'($urandom));
      if (k < 2) b = 8'($urandom);
      else if (k % 2 == 0) b = plan_words[(k - 2) / 2][15:8];
      else b = plan_words[(k - 2) / 2][7:0];
      send_item(OP_BYTE, b);
    end
  endtask

  task automatic send_junk(int n_bytes, int n_ticks);
    repeat (n_bytes) send_item(OP_BYTE, 8'($urandom));
    repeat (n_ticks) send_item(OP_TICK, 8'($urandom));
  endtask

  // Reset settings: 11-bit values, slot remap, extremes, count 13 reported as 12
  task automatic test_reset_defaults();
    plan_words[0] = pack_word(4'd0, 11'h000, 2'b01);
    plan_words[1] = pack_word(4'd1, 11'h7ff, 2'b00);
    plan_words[2] = pack_word(4'd2, 11'h400, 2'b01);
    plan_words[3] = pack_word(4'd12, 11'h001, 2'b00);
    plan_words[4] = pack_word(4'd3, 11'h7fe, 2'b00);
    plan_words[5] = pack_word(4'd4, 11'h155, 2'b01);
    plan_words[6] = pack_word(4'd5, 11'h2aa, 2'b00);
    send_frame(0, -1, 0);
  endtask

  // 10-bit values, top bits ignored, highest channel
  task automatic test_narrow_values();
    write_reg(CFG_WIDE_VALUES, 8'd0);
    plan_words[0] = pack_word(4'd15, 11'h3ff, 2'b11);
    plan_words[1] = pack_word(4'd7, 11'h000, 2'b10);
    plan_words[2] = pack_word(4'd13, 11'h200, 2'b01);
    plan_words[3] = pack_word(4'd14, 11'h155, 2'b00);
    plan_words[4] = pack_word(4'd0, 11'h3ff, 2'b11);
    plan_words[5] = pack_word(4'd1, 11'h001, 2'b00);
    plan_words[6] = pack_word(4'd2, 11'h2aa, 2'b10);
    send_frame(0, -1, 0);
  endtask

  // Idle exactly at the limit keeps the frame; one more tick restarts it
  task automatic test_gap_limit();
    write_reg(CFG_WIDE_VALUES, 8'd1);
    write_reg(CFG_GAP_LIMIT, 8'd3);
    fill_random_words();
    send_frame(0, 4, 3);
    send_junk(4, 4);
    fill_random_words();
    send_frame(0, -1, 0);
    write_reg(CFG_GAP_LIMIT, 8'd0);
    send_junk(2, 1);
    fill_random_words();
    send_frame(0, -1, 0);
  endtask

  // Idle count saturates rather than wrapping: 256 ticks under an unlimited gap
  // leave it at 255, so a limit of 254 must restart the partial frame
  task automatic test_idle_saturation();
    write_reg(CFG_GAP_LIMIT, 8'd255);
    send_junk(3, 256);
    write_reg(CFG_GAP_LIMIT, 8'd254);
    fill_random_words();
    send_frame(0, -1, 0);
  endtask

  // Receiver holds off for a long stretch while frames keep coming
  task automatic test_output_backpressure();
    int f;
    write_reg(CFG_GAP_LIMIT, 8'd5);
    hold_left = 300;
    for (f = 0; f < 2; f++) begin
      fill_random_words();
      send_frame(0, -1, 0);
    end
    wait_quiet();
  endtask

  // Random phases: mostly well-formed frames, some noise and cut-off frames
  task automatic test_random_frames();
    int phase;
    int f;
    int gap;
    int max_t;
    for (phase = 0; phase < 4; phase++) begin
      write_reg(CFG_WIDE_VALUES, (phase < 2) ? 8'(phase) : 8'($urandom_range(0, 1)));
      case (phase)
        0:       gap = 0;
        1:       gap = 255;
        2:       gap = 5;
        default: gap = $urandom_range(1, 30);
      endcase
      write_reg(CFG_GAP_LIMIT, 8'(gap));
      if (gap < 255) send_junk(0, gap + 1);
      max_t = (gap < 4) ? gap : 4;
      for (f = 0; f < 2; f++) begin
        case ($urandom_range(0, 9))
          0: send_junk($urandom_range(1, 15), $urandom_range(0, (gap < 255) ? gap + 2 : 4));
          1: send_junk($urandom_range(1, 15), (gap < 255) ? gap + 1 : 0);
          default: begin
            fill_random_words();
            send_frame(max_t, -1, 0);
          end
        endcase
      end
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.operation  = OP_BYTE;
    in_if.rx_byte    = '0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.reg_index = CFG_WIDE_VALUES;
    cfg_if.wdata     = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_narrow_values();
    test_gap_limit();
    test_idle_saturation();
    test_output_backpressure();
    test_random_frames();

    wait_quiet();
    if (error_count == 0 && pending_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
src/dsmrc_pkg.sv
src/dsmrc_in_if.sv
src/dsmrc_out_if.sv
src/dsmrc_cfg_if.sv
src/dsmrc_ram.sv
src/dsm_rc_frame_decoder_unit.sv
sim/tb.sv
